// ----- design/dsbtc_pkg.sv -----
// Shared types and constants for the dual shelf biquad tone control.
// Holds the transfer payload structs, the history row layout and the microcode word format.
// No dependencies.
`timescale 1ns / 1ps

package dsbtc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CHAN_BITS   = 3;
  localparam int COEF_W      = 32;
  localparam int HIST_W      = 32;
  localparam int PROD_W      = 2 * COEF_W;
  localparam int ACC_W       = PROD_W + 12;
  localparam int CFG_W       = 64;
  localparam int NUM_REGS    = 5;
  localparam int REG_IDX_W   = 3;
  localparam int STEP_W      = 4;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_BASS_B0_B1        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASS_B2_A1        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BASS_A2_TREBLE_B0 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TREBLE_B1_B2      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TREBLE_A1_A2      = 3'd4;

  // Microcode step addresses.
  localparam logic [STEP_W-1:0] ST_WAIT       = 4'd0;
  localparam logic [STEP_W-1:0] ST_BASS_B0    = 4'd1;
  localparam logic [STEP_W-1:0] ST_BASS_B1    = 4'd2;
  localparam logic [STEP_W-1:0] ST_BASS_B2    = 4'd3;
  localparam logic [STEP_W-1:0] ST_BASS_A1    = 4'd4;
  localparam logic [STEP_W-1:0] ST_BASS_A2    = 4'd5;
  localparam logic [STEP_W-1:0] ST_TREB_B1    = 4'd6;
  localparam logic [STEP_W-1:0] ST_TREB_B2    = 4'd7;
  localparam logic [STEP_W-1:0] ST_TREB_A1    = 4'd8;
  localparam logic [STEP_W-1:0] ST_TREB_A2    = 4'd9;
  localparam logic [STEP_W-1:0] ST_TREB_B0    = 4'd10;
  localparam logic [STEP_W-1:0] ST_TREB_DRAIN = 4'd11;
  localparam logic [STEP_W-1:0] ST_TREB_FIN   = 4'd12;
  localparam logic [STEP_W-1:0] ST_OUT        = 4'd13;
  localparam logic [STEP_W-1:0] ST_BYPASS     = 4'd14;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;
  } out_item_t;

  // One history row per channel: the two delayed taps of every stage.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [HIST_W-1:0]      yb1;
    logic signed [HIST_W-1:0]      yb2;
    logic signed [HIST_W-1:0]      yt1;
    logic signed [HIST_W-1:0]      yt2;
  } hist_row_t;

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_bank_t;

  typedef enum logic [3:0] {
    C_BASS_B0, C_BASS_B1, C_BASS_B2, C_BASS_A1, C_BASS_A2,
    C_TREB_B0, C_TREB_B1, C_TREB_B2, C_TREB_A1, C_TREB_A2
  } coef_sel_t;

  typedef enum logic [2:0] {
    OP_X, OP_X1, OP_X2, OP_YB1, OP_YB2, OP_YB, OP_YT1, OP_YT2
  } opnd_sel_t;

  typedef enum logic [1:0] {
    COND_NEXT, COND_JUMP, COND_WAIT_IN, COND_WAIT_OUT
  } cond_t;

  typedef struct packed {
    logic              in_rdy;
    logic              mul_en;
    coef_sel_t         coef;
    opnd_sel_t         opnd;
    logic              int_op;
    logic              sub;
    logic              first;
    logic              fin_bass;
    logic              fin_treb;
    logic              out_load;
    logic              out_bypass;
    logic              hist_wr;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic in_range;
    logic out_free;
  } seq_status_t;

endpackage

// ----- design/dsbtc_sequencer.sv -----
// Microcode sequencer: step counter, control store and jump logic.
// Depends on dsbtc_pkg for the control word and status types.
`timescale 1ns / 1ps

module dsbtc_sequencer
  import dsbtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ucode_t      cw
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  // Control store. Each multiply step feeds the accumulator through the registered product.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    w = '0;
    w.cond   = COND_NEXT;
    w.target = ST_WAIT;
    case (addr)
      ST_WAIT: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_WAIT_IN;
        w.target = ST_BYPASS;
      end
      ST_BASS_B0: begin
        w.mul_en = 1'b1; w.coef = C_BASS_B0; w.opnd = OP_X;
        w.int_op = 1'b1; w.first = 1'b1;
      end
      ST_BASS_B1: begin
        w.mul_en = 1'b1; w.coef = C_BASS_B1; w.opnd = OP_X1; w.int_op = 1'b1;
      end
      ST_BASS_B2: begin
        w.mul_en = 1'b1; w.coef = C_BASS_B2; w.opnd = OP_X2; w.int_op = 1'b1;
      end
      ST_BASS_A1: begin
        w.mul_en = 1'b1; w.coef = C_BASS_A1; w.opnd = OP_YB1; w.sub = 1'b1;
      end
      ST_BASS_A2: begin
        w.mul_en = 1'b1; w.coef = C_BASS_A2; w.opnd = OP_YB2; w.sub = 1'b1;
      end
      ST_TREB_B1: begin
        w.mul_en = 1'b1; w.coef = C_TREB_B1; w.opnd = OP_YB1; w.first = 1'b1;
      end
      ST_TREB_B2: begin
        w.mul_en = 1'b1; w.coef = C_TREB_B2; w.opnd = OP_YB2; w.fin_bass = 1'b1;
      end
      ST_TREB_A1: begin
        w.mul_en = 1'b1; w.coef = C_TREB_A1; w.opnd = OP_YT1; w.sub = 1'b1;
      end
      ST_TREB_A2: begin
        w.mul_en = 1'b1; w.coef = C_TREB_A2; w.opnd = OP_YT2; w.sub = 1'b1;
      end
      ST_TREB_B0: begin
        w.mul_en = 1'b1; w.coef = C_TREB_B0; w.opnd = OP_YB;
      end
      ST_TREB_DRAIN: begin
        w.cond = COND_NEXT;
      end
      ST_TREB_FIN: begin
        w.fin_treb = 1'b1;
      end
      ST_OUT: begin
        w.out_load = 1'b1;
        w.hist_wr  = 1'b1;
        w.cond     = COND_WAIT_OUT;
        w.target   = ST_WAIT;
      end
      ST_BYPASS: begin
        w.out_load   = 1'b1;
        w.out_bypass = 1'b1;
        w.cond       = COND_WAIT_OUT;
        w.target     = ST_WAIT;
      end
      default: begin
        w.cond   = COND_JUMP;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

  assign cw = ucode_rom(step);

  always_comb begin
    case (cw.cond)
      COND_NEXT: step_next = step + 1'b1;
      COND_JUMP: step_next = cw.target;
      COND_WAIT_IN: begin
        if (!status.in_valid) begin
          step_next = step;
        end else if (!status.in_range) begin
          step_next = cw.target;
        end else begin
          step_next = step + 1'b1;
        end
      end
      COND_WAIT_OUT: step_next = status.out_free ? cw.target : step;
      default: step_next = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- design/dsbtc_history.sv -----
// Per-channel filter history memory with a valid bit per row.
// Depends on dsbtc_pkg for the row layout.
`timescale 1ns / 1ps

module dsbtc_history
  import dsbtc_pkg::*;
#(
  parameter int CHANNELS = 8,
  parameter int ADDR_W   = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  hist_row_t         wr_row,
  output hist_row_t         rd_row
);

  hist_row_t           mem [CHANNELS];
  logic [CHANNELS-1:0] row_valid;
  hist_row_t           rd_data;
  logic                rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // A row never written since reset reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= row_valid[rd_addr];
      end
    end
  end

  assign rd_row = rd_hit ? rd_data : '0;

endmodule

// ----- design/dsbtc_mac.sv -----
// Shared multiply-accumulate datapath driven by the microcode word.
// Depends on dsbtc_pkg for the control word, history row and register bank types.
`timescale 1ns / 1ps

module dsbtc_mac
  import dsbtc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  ucode_t                        cw,
  input  cfg_bank_t                     cfg,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  hist_row_t                     row,
  output logic signed [HIST_W-1:0]      yb,
  output logic signed [HIST_W-1:0]      yt
);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << 27;

  logic signed [COEF_W-1:0] coef;
  logic signed [COEF_W-1:0] opnd;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic                     prod_int;
  logic                     prod_sub;
  logic                     prod_first;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  acc;

  // Round half up from scale 2^-36 to Q24.8, then clamp to 32 bits.
  function automatic logic signed [HIST_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] q;
    t = v + ROUND_HALF;
    q = t >>> 28;
    if (q[ACC_W-1:HIST_W-1] == '0 || q[ACC_W-1:HIST_W-1] == '1) begin
      return q[HIST_W-1:0];
    end else if (q[ACC_W-1]) begin
      return {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(HIST_W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    case (cw.coef)
      C_BASS_B0: coef = cfg[REG_BASS_B0_B1][63:32];
      C_BASS_B1: coef = cfg[REG_BASS_B0_B1][31:0];
      C_BASS_B2: coef = cfg[REG_BASS_B2_A1][63:32];
      C_BASS_A1: coef = cfg[REG_BASS_B2_A1][31:0];
      C_BASS_A2: coef = cfg[REG_BASS_A2_TREBLE_B0][63:32];
      C_TREB_B0: coef = cfg[REG_BASS_A2_TREBLE_B0][31:0];
      C_TREB_B1: coef = cfg[REG_TREBLE_B1_B2][63:32];
      C_TREB_B2: coef = cfg[REG_TREBLE_B1_B2][31:0];
      C_TREB_A1: coef = cfg[REG_TREBLE_A1_A2][63:32];
      C_TREB_A2: coef = cfg[REG_TREBLE_A1_A2][31:0];
      default:   coef = '0;
    endcase
  end

  always_comb begin
    case (cw.opnd)
      OP_X:    opnd = COEF_W'(x);
      OP_X1:   opnd = COEF_W'(row.x1);
      OP_X2:   opnd = COEF_W'(row.x2);
      OP_YB1:  opnd = row.yb1;
      OP_YB2:  opnd = row.yb2;
      OP_YB:   opnd = yb;
      OP_YT1:  opnd = row.yt1;
      OP_YT2:  opnd = row.yt2;
      default: opnd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw.mul_en) begin
      prod <= coef * opnd;
    end
    prod_int   <= cw.int_op;
    prod_sub   <= cw.sub;
    prod_first <= cw.first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= cw.mul_en;
    end
  end

  // Integer samples carry eight fewer fraction bits than the Q24.8 taps.
  always_comb begin
    addend   = prod_int ? (ACC_W'(prod) <<< 8) : ACC_W'(prod);
    acc_base = prod_first ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      acc <= prod_sub ? (acc_base - addend) : (acc_base + addend);
    end
    if (cw.fin_bass) begin
      yb <= round_sat(acc);
    end
    if (cw.fin_treb) begin
      yt <= round_sat(acc);
    end
  end

endmodule

// ----- design/dual_shelf_biquad_tone_control.sv -----
// Top level of the dual shelf biquad tone control.
// Depends on dsbtc_pkg, dsbtc_sequencer, dsbtc_mac and dsbtc_history.
//
// Usage:
// Each input transfer carries one signed sample and a channel number. The sample
// passes through a bass low-shelf biquad and then a treble high-shelf biquad, both
// direct form I with their own history for every channel, and one output transfer
// carries the rounded, saturated result with a flag that marks clipping.
// The coefficient registers are written through cfg_we/cfg_index/cfg_data; a write
// takes effect at once and should only be made while no sample is in flight.
// Sequencing: a microcoded sequencer runs all ten products of an item through one shared
// 32x32 multiplier, one product per cycle. A filtered sample is loaded into the output
// register in the output step at the end of the program; the input opens only in the
// wait step, so a new item is not taken before the last one has been loaded.
// A bypassed channel with no history slot is loaded in the bypass step after the wait step.
// Reset clears the sequencer, the output valid and the valid bits of the history
// memory, so every channel starts from a silent history; the coefficients return
// to a flat response. If the receiver stalls, the finished result waits in the
// output register and the sequencer holds in its output step until the register
// frees, so no result is ever dropped and no new input is taken meanwhile.
`timescale 1ns / 1ps

module dual_shelf_biquad_tone_control
  import dsbtc_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Flat response after reset: both b0 coefficients are 1.0 in Q4.28.
  localparam logic [CFG_W-1:0] RESET_BASS_B0_B1        = 64'h1000_0000_0000_0000;
  localparam logic [CFG_W-1:0] RESET_BASS_A2_TREBLE_B0 = 64'h0000_0000_1000_0000;
  // The whole bank, listed from the highest register index down.
  localparam cfg_bank_t RESET_BANK = {64'h0, 64'h0, RESET_BASS_A2_TREBLE_B0, 64'h0,
                                      RESET_BASS_B0_B1};

  cfg_bank_t                     cfg;
  ucode_t                        cw;
  seq_status_t                   status;
  logic                          in_range;
  logic                          in_xfer;
  logic                          out_free;
  logic                          out_load;
  logic [CHAN_BITS-1:0]          chan;
  logic [ADDR_W-1:0]             addr;
  logic signed [SAMPLE_BITS-1:0] x;
  hist_row_t                     rd_row;
  hist_row_t                     wr_row;
  logic signed [HIST_W-1:0]      yb;
  logic signed [HIST_W-1:0]      yt;
  logic signed [HIST_W:0]        yt_round;
  logic                          out_fits;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  out_item_t                     out_item;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= RESET_BANK;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASS_B0_B1:        cfg[REG_BASS_B0_B1]        <= cfg_data;
        REG_BASS_B2_A1:        cfg[REG_BASS_B2_A1]        <= cfg_data;
        REG_BASS_A2_TREBLE_B0: cfg[REG_BASS_A2_TREBLE_B0] <= cfg_data;
        REG_TREBLE_B1_B2:      cfg[REG_TREBLE_B1_B2]      <= cfg_data;
        REG_TREBLE_A1_A2:      cfg[REG_TREBLE_A1_A2]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input side is open only while the sequencer sits in its wait step.
  assign in_ready = cw.in_rdy;
  assign in_xfer  = in_valid && in_ready;
  assign in_range = 32'(in_data.channel) < CHANNELS;

  assign out_free = !out_valid || out_ready;
  assign out_load = cw.out_load && out_free;

  assign status.in_valid = in_valid;
  assign status.in_range = in_range;
  assign status.out_free = out_free;

  // The sample and channel are held for the whole program of one item.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      chan <= in_data.channel;
      addr <= ADDR_W'(in_data.channel);
      x    <= in_data.sample_in;
    end
  end

  dsbtc_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw)
  );

  dsbtc_mac u_mac (
    .clk (clk),
    .rst (rst),
    .cw  (cw),
    .cfg (cfg),
    .x   (x),
    .row (rd_row),
    .yb  (yb),
    .yt  (yt)
  );

  // The history row shifts by one tap when the filtered result leaves.
  assign wr_row.x1  = x;
  assign wr_row.x2  = rd_row.x1;
  assign wr_row.yb1 = yb;
  assign wr_row.yb2 = rd_row.yb1;
  assign wr_row.yt1 = yt;
  assign wr_row.yt2 = rd_row.yt1;

  dsbtc_history #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (ADDR_W)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_xfer && in_range),
    .rd_addr (ADDR_W'(in_data.channel)),
    .wr_en   (cw.hist_wr && out_free),
    .wr_addr (addr),
    .wr_row  (wr_row),
    .rd_row  (rd_row)
  );

  // Round the Q24.8 treble result to an integer and saturate it to the sample width.
  always_comb begin
    yt_round = {yt[HIST_W-1], yt} + (HIST_W + 1)'(128);
    out_fits = (yt_round[HIST_W:SAMPLE_BITS+7] == '0) ||
               (yt_round[HIST_W:SAMPLE_BITS+7] == '1);
    if (out_fits) begin
      out_sample = yt_round[SAMPLE_BITS+7:8];
    end else if (yt_round[HIST_W]) begin
      out_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      out_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_comb begin
    out_item.channel_out = chan;
    if (cw.out_bypass) begin
      out_item.sample_out = x;
      out_item.clipped    = 1'b0;
    end else begin
      out_item.sample_out = out_sample;
      out_item.clipped    = !out_fits;
    end
  end

  // Output register: holds a finished result until the receiver takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_item;
    end
  end

endmodule
